### hdl/sksel_pkg.sv
// ----------------------------------------------------------------------------
// sksel_pkg
// Shared types and constants of the smallest-k index selector.
// ----------------------------------------------------------------------------
package sksel_pkg;

    localparam int MAX_KEEP   = 8;
    localparam int INDEX_BITS = 16;
    localparam int SCORE_W    = 32;
    localparam int KEEP_W     = 4;
    localparam int CHOSEN_W   = 4;
    localparam int COUNT_W    = $clog2(MAX_KEEP + 1);
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Largest positive Q16.16 value marks an empty slot
    localparam logic signed [SCORE_W-1:0] EMPTY_SCORE = 32'sh7FFF_FFFF;

    // Register word addresses
    localparam logic REG_KEEP_COUNT = 1'b0;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_EMIT
    } t_state;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

### hdl/sksel_cell.sv
// ----------------------------------------------------------------------------
// sksel_cell
// One slot of the sorted list: holds a score and its index, compares the
// broadcast candidate and trades contents with its neighbors.
// ----------------------------------------------------------------------------
module sksel_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sksel_pkg::t_cell_ctrl                  i_ctrl,
    input  logic                                   i_enable,
    input  logic signed [sksel_pkg::SCORE_W-1:0]   i_new_score,
    input  logic [sksel_pkg::INDEX_BITS-1:0]       i_new_index,
    input  logic                                   i_prev_found,
    input  logic                                   i_prev_lead,
    input  logic signed [sksel_pkg::SCORE_W-1:0]   i_prev_score,
    input  logic [sksel_pkg::INDEX_BITS-1:0]       i_prev_index,
    input  logic signed [sksel_pkg::SCORE_W-1:0]   i_next_score,
    input  logic [sksel_pkg::INDEX_BITS-1:0]       i_next_index,
    output logic                                   o_found,
    output logic                                   o_lead,
    output logic signed [sksel_pkg::SCORE_W-1:0]   o_score,
    output logic [sksel_pkg::INDEX_BITS-1:0]       o_index
);
    import sksel_pkg::*;

    logic signed [SCORE_W-1:0] r_score;
    logic signed [SCORE_W-1:0] n_score;
    logic [INDEX_BITS-1:0]     r_index;
    logic [INDEX_BITS-1:0]     n_index;
    logic                      w_less;

    assign w_less  = i_enable && (i_new_score < r_score);
    assign o_found = i_prev_found || w_less;
    // Leading run of non-positive scores within the kept slots
    assign o_lead  = i_prev_lead && i_enable && (r_score[SCORE_W-1] || (r_score == '0));
    assign o_score = r_score;
    assign o_index = r_index;

    always_comb begin
        n_score = r_score;
        n_index = r_index;
        priority if (i_ctrl.clear) begin
            n_score = EMPTY_SCORE;
        end else if (i_ctrl.shift) begin
            n_score = i_next_score;
            n_index = i_next_index;
        end else if (i_ctrl.insert && i_enable) begin
            // An insertion above pushes this slot down; otherwise a smaller candidate lands here
            priority if (i_prev_found) begin
                n_score = i_prev_score;
                n_index = i_prev_index;
            end else if (w_less) begin
                n_score = i_new_score;
                n_index = i_new_index;
            end else begin
                // hold
                n_score = r_score;
                n_index = r_index;
            end
        end else begin
            // hold
            n_score = r_score;
            n_index = r_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= EMPTY_SCORE;
        end else begin
            r_score <= n_score;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index <= n_index;
    end

endmodule

### hdl/sksel_chain.sv
// ----------------------------------------------------------------------------
// sksel_chain
// Row of list cells, slot 0 holding the smallest score.
// ----------------------------------------------------------------------------
module sksel_chain (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sksel_pkg::t_cell_ctrl                  i_ctrl,
    input  logic [sksel_pkg::MAX_KEEP-1:0]         i_enable,
    input  logic signed [sksel_pkg::SCORE_W-1:0]   i_new_score,
    input  logic [sksel_pkg::INDEX_BITS-1:0]       i_new_index,
    output logic [sksel_pkg::INDEX_BITS-1:0]       o_head_index,
    output logic [sksel_pkg::MAX_KEEP-1:0]         o_lead
);
    import sksel_pkg::*;

    logic [MAX_KEEP-1:0]       w_found;
    logic signed [SCORE_W-1:0] w_score [MAX_KEEP];
    logic [INDEX_BITS-1:0]     w_index [MAX_KEEP];

    for (genvar j = 0; j < MAX_KEEP; j++) begin : g_cell
        logic                      w_prev_found;
        logic                      w_prev_lead;
        logic signed [SCORE_W-1:0] w_prev_score;
        logic [INDEX_BITS-1:0]     w_prev_index;
        logic signed [SCORE_W-1:0] w_next_score;
        logic [INDEX_BITS-1:0]     w_next_index;

        if (j == 0) begin : g_head
            assign w_prev_found = 1'b0;
            assign w_prev_lead  = 1'b1;
            assign w_prev_score = EMPTY_SCORE;
            assign w_prev_index = '0;
        end else begin : g_body
            assign w_prev_found = w_found[j-1];
            assign w_prev_lead  = o_lead[j-1];
            assign w_prev_score = w_score[j-1];
            assign w_prev_index = w_index[j-1];
        end

        if (j == MAX_KEEP - 1) begin : g_tail
            assign w_next_score = EMPTY_SCORE;
            assign w_next_index = '0;
        end else begin : g_inner
            assign w_next_score = w_score[j+1];
            assign w_next_index = w_index[j+1];
        end

        sksel_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (i_ctrl),
            .i_enable     (i_enable[j]),
            .i_new_score  (i_new_score),
            .i_new_index  (i_new_index),
            .i_prev_found (w_prev_found),
            .i_prev_lead  (w_prev_lead),
            .i_prev_score (w_prev_score),
            .i_prev_index (w_prev_index),
            .i_next_score (w_next_score),
            .i_next_index (w_next_index),
            .o_found      (w_found[j]),
            .o_lead       (o_lead[j]),
            .o_score      (w_score[j]),
            .o_index      (w_index[j])
        );
    end

    assign o_head_index = w_index[0];

endmodule

### hdl/smallest_k_index_selector.sv
// ----------------------------------------------------------------------------
// smallest_k_index_selector
// Keeps the keep_count smallest scores of a candidate set in a sorted cell
// chain and, after the final candidate, returns the indices of those that are
// zero or negative.
// ----------------------------------------------------------------------------
// One candidate is taken per cycle while a set is collected: every cell of the
// chain compares and shifts in the same cycle. After the final candidate the
// input stalls while the qualifying entries are counted, then one result per
// cycle is moved into the output register as it frees up, the chain shifting
// up one slot per result. The input stays stalled until the final result has
// been loaded into the output register. A set with no qualifying entry returns
// a single result with list_empty set. keep_count (register 0) is to be
// written over the APB port only while the block is idle; the block itself
// does not enforce this. 0 acts as 1 and values above the list size act as
// the list size.
module smallest_k_index_selector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // candidate stream
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [sksel_pkg::SCORE_W-1:0] i_score_value,
    input  logic [sksel_pkg::INDEX_BITS-1:0]     i_entry_index,
    input  logic                                 i_final_item,
    // result stream
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [sksel_pkg::INDEX_BITS-1:0]     o_chosen_index,
    output logic [sksel_pkg::CHOSEN_W-1:0]       o_chosen_count,
    output logic                                 o_list_empty,
    output logic                                 o_run_last,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sksel_pkg::ADDR_W-1:0]         paddr,
    input  logic [sksel_pkg::DATA_W-1:0]         pwdata,
    output logic [sksel_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready
);
    import sksel_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [KEEP_W-1:0]     r_keep_count;
    logic [CHOSEN_W-1:0]   r_count;
    logic [COUNT_W-1:0]    r_remain;
    logic [COUNT_W-1:0]    w_lead_count;
    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_chosen_index;
    logic [CHOSEN_W-1:0]   r_chosen_count;
    logic                  r_list_empty;
    logic                  r_run_last;

    t_cell_ctrl            w_ctrl;
    logic [MAX_KEEP-1:0]   w_enable;
    logic [MAX_KEEP-1:0]   w_lead;
    logic [INDEX_BITS-1:0] w_head_index;
    logic                  w_in_xfer;
    logic                  w_out_free;
    logic                  w_load;
    logic                  w_last;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_KEEP_COUNT) ? DATA_W'(r_keep_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= KEEP_RESET;
        end else if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_KEEP_COUNT)) begin
            r_keep_count <= pwdata[KEEP_W-1:0];
        end
    end

    // Slot 0 is always live, so a keep_count of zero acts as one
    for (genvar j = 0; j < MAX_KEEP; j++) begin : g_enable
        assign w_enable[j] = (j == 0) || (j < int'(r_keep_count));
    end

    // ---------------- handshakes ----------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_lead_count = '0;
        for (int j = 0; j < MAX_KEEP; j++) begin
            w_lead_count = w_lead_count + COUNT_W'(w_lead[j]);
        end
    end

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && i_final_item) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctrl = '0;
        w_load = 1'b0;
        w_last = (r_remain <= COUNT_W'(1));
        unique case (r_state)
            S_IDLE: begin
                w_ctrl.insert = w_in_xfer;
            end
            S_COUNT: begin
                w_ctrl = '0;
            end
            S_EMIT: begin
                w_load       = w_out_free;
                // Drop the emitted head, or empty the list after the final result
                w_ctrl.shift = w_out_free && !w_last;
                w_ctrl.clear = w_out_free && w_last;
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COUNT) begin
            r_count  <= CHOSEN_W'(w_lead_count);
            r_remain <= w_lead_count;
        end else if (w_load) begin
            r_remain <= r_remain - COUNT_W'(r_remain != '0);
        end
    end

    // ---------------- list ----------------
    sksel_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_enable     (w_enable),
        .i_new_score  (i_score_value),
        .i_new_index  (i_entry_index),
        .o_head_index (w_head_index),
        .o_lead       (w_lead)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_chosen_index <= (r_remain == '0) ? '0 : w_head_index;
            r_chosen_count <= r_count;
            r_list_empty   <= (r_remain == '0);
            r_run_last     <= w_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_chosen_index = r_chosen_index;
    assign o_chosen_count = r_chosen_count;
    assign o_list_empty   = r_list_empty;
    assign o_run_last     = r_run_last;

endmodule

### hdl/sksel_checker.sv
// ----------------------------------------------------------------------------
// sksel_checker
// Port-level checks of the smallest-k index selector.
// ----------------------------------------------------------------------------
module sksel_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 i_final_item,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic [sksel_pkg::INDEX_BITS-1:0]     o_chosen_index,
    input logic [sksel_pkg::CHOSEN_W-1:0]       o_chosen_count,
    input logic                                 o_list_empty,
    input logic                                 o_run_last
);
    import sksel_pkg::*;

    // The final candidate closes the set: input holds while results are formed
    a_final_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_final_item) |=> o_in_stall)
        else $error("input not stalled after final candidate");

    // An empty set gives exactly one result, with no count
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_list_empty) |-> (o_run_last && (o_chosen_count == '0)))
        else $error("empty result malformed");

    // A non-empty result always carries a nonzero count
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_list_empty) |-> (o_chosen_count != '0))
        else $error("result without count");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_chosen_index) && $stable(o_run_last)))
        else $error("stalled result changed");

endmodule

bind smallest_k_index_selector sksel_checker u_sksel_checker (.*);
